@@ sv/sar_pkg.sv @@
package sar_pkg;

  localparam int ADDR_W     = 32;
  localparam int CNT_W      = 32;
  localparam int CLASS_W    = 5;
  localparam int REG_W      = 2;
  localparam int SLAB_SLOTS = 64;

  localparam logic [REG_W-1:0] REG_MIN_CLASS  = 2'd0;
  localparam logic [REG_W-1:0] REG_SLAB_LIMIT = 2'd1;
  localparam logic [REG_W-1:0] REG_REGION     = 2'd2;

  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;
  localparam logic [1:0] ST_SPACE = 2'd3;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CLASS,
    S_SCAN,
    S_DECIDE,
    S_REL_RD,
    S_REL_WR,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [CLASS_W-1:0] cls;
    logic [ADDR_W-1:0]  base;
    logic [CNT_W-1:0]   acq;
  } slab_ent_t;

  typedef struct packed {
    logic               found;
    logic               err;
    logic [CLASS_W-1:0] cls;
    logic [ADDR_W-1:0]  base;
    logic [CNT_W-1:0]   acq;
  } best_t;

  function automatic logic [CLASS_W:0] ceil_log2(input logic [31:0] x);
    logic [31:0]        xm;
    logic [CLASS_W:0]   r;
    xm = x - 32'd1;
    r  = '0;
    for (int i = 0; i < 32; i++) begin
      if (xm[i]) begin
        r = 6'(i + 1);
      end
    end
    if (x <= 32'd1) begin
      r = '0;
    end
    return r;
  endfunction

endpackage

@@ sv/slab_allocator_refcount.sv @@
// Channel   Direction  Handshake             Beat contents
// config    in         cfg_write             cfg_index, cfg_data
// request   in         in_valid / in_ready   opcode, request_bytes, release_slab
// result    out        out_valid / out_ready status, granted_slab, slab_address
//
// An acquire's result is loaded once the S_SCAN state has read the slab table and S_DECIDE
// has chosen a slab: the table is read one entry per cycle through the single read port
// of each memory. An in-range release's result is loaded after states S_REL_RD, S_REL_WR.
// After reset the release counts are cleared one entry at a time in S_CLEAR, during which
// no request beat is taken. A request may be taken while the previous result still waits
// in the output register; the block stalls only at the hand-over.
module slab_allocator_refcount (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [sar_pkg::REG_W-1:0]     cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          opcode,
  input  logic [31:0]                   request_bytes,
  input  logic [5:0]                    release_slab,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    status,
  output logic [5:0]                    granted_slab,
  output logic [31:0]                   slab_address
);
  import sar_pkg::*;

  localparam int IW = (SLAB_SLOTS > 1) ? $clog2(SLAB_SLOTS) : 1;
  localparam int NW = $clog2(SLAB_SLOTS + 1);

  state_t state, state_next;

  logic [CLASS_W-1:0] min_class_exp;
  logic [6:0]         slab_limit;
  logic [31:0]        region_bytes;

  logic               op;
  logic [31:0]        req;
  logic [5:0]         rel_slab;
  logic [CLASS_W:0]   cls;
  logic [NW-1:0]      scan_idx;
  logic               pend;
  logic [IW-1:0]      pend_idx;
  logic [NW-1:0]      slabs_made;
  logic [ADDR_W:0]    bump_offset;
  logic [IW-1:0]      clr_idx;
  logic [1:0]         res_status;
  logic [5:0]         res_slab;
  logic [ADDR_W-1:0]  res_addr;

  logic               slab_we;
  logic [IW-1:0]      slab_waddr;
  slab_ent_t          slab_wdata;
  slab_ent_t          slab_rdata;
  logic               rel_we;
  logic [IW-1:0]      rel_waddr;
  logic [CNT_W-1:0]   rel_wdata;
  logic [IW-1:0]      rel_raddr;
  logic [CNT_W-1:0]   rel_rdata;

  best_t              best;
  logic [IW-1:0]      best_idx;

  logic               accept;
  logic               issue;
  logic               out_load;
  logic               rel_ok;
  logic               pool_full;
  logic               no_space;
  logic [ADDR_W:0]    size;
  logic [ADDR_W+1:0]  end_offset;
  logic [CLASS_W:0]   cls_raw;

  sar_ram #(.WIDTH($bits(slab_ent_t)), .DEPTH(SLAB_SLOTS)) u_slab_ram (
    .clk   (clk),
    .we    (slab_we),
    .waddr (slab_waddr),
    .wdata (slab_wdata),
    .raddr (scan_idx[IW-1:0]),
    .rdata (slab_rdata)
  );

  sar_ram #(.WIDTH(CNT_W), .DEPTH(SLAB_SLOTS)) u_rel_ram (
    .clk   (clk),
    .we    (rel_we),
    .waddr (rel_waddr),
    .wdata (rel_wdata),
    .raddr (rel_raddr),
    .rdata (rel_rdata)
  );

  sar_scan #(.IW(IW)) u_scan (
    .clk       (clk),
    .start     (state == S_CLASS),
    .ent_valid (pend),
    .ent       (slab_rdata),
    .ent_rel   (rel_rdata),
    .ent_idx   (pend_idx),
    .cls       (cls),
    .best      (best),
    .best_idx  (best_idx)
  );

  always_comb begin
    rel_ok     = 32'(release_slab) < 32'(SLAB_SLOTS);
    cls_raw    = ceil_log2(req);
    size       = (ADDR_W + 1)'(1) << cls;
    end_offset = {1'b0, bump_offset} + {1'b0, size};
    pool_full  = (32'(slabs_made) >= 32'(slab_limit)) ||
                 (32'(slabs_made) >= 32'(SLAB_SLOTS));
    no_space   = cls[CLASS_W] || (end_offset > (ADDR_W + 2)'(region_bytes));
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_idx == IW'(SLAB_SLOTS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          if (opcode == OP_ACQUIRE) begin
            state_next = S_CLASS;
          end else if (rel_ok) begin
            state_next = S_REL_RD;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_CLASS: state_next = S_SCAN;
      S_SCAN: begin
        if ((scan_idx >= slabs_made) && !pend) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: state_next = S_FINISH;
      S_REL_RD: state_next = S_REL_WR;
      S_REL_WR: state_next = S_FINISH;
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state == S_IDLE);
    accept     = in_valid && in_ready;
    issue      = (state == S_SCAN) && (scan_idx < slabs_made);
    out_load   = (state == S_FINISH) && (!out_valid || out_ready);
    slab_we    = 1'b0;
    slab_waddr = best_idx;
    slab_wdata = '{cls: best.cls, base: best.base, acq: best.acq + CNT_W'(1)};
    rel_we     = 1'b0;
    rel_waddr  = IW'(rel_slab);
    rel_wdata  = rel_rdata + CNT_W'(1);
    rel_raddr  = IW'(rel_slab);
    case (state)
      S_CLEAR: begin
        rel_we    = 1'b1;
        rel_waddr = clr_idx;
        rel_wdata = '0;
      end
      S_SCAN: begin
        rel_raddr = scan_idx[IW-1:0];
      end
      S_DECIDE: begin
        if (best.found) begin
          slab_we = !best.err;
        end else if (!pool_full && !no_space) begin
          slab_we    = 1'b1;
          slab_waddr = slabs_made[IW-1:0];
          slab_wdata = '{cls: cls[CLASS_W-1:0], base: bump_offset[ADDR_W-1:0],
                         acq: CNT_W'(1)};
        end
      end
      S_REL_WR: begin
        rel_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_class_exp <= CLASS_W'(8);
      slab_limit    <= 7'd64;
      region_bytes  <= 32'hFFFF_FFFF;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MIN_CLASS:  min_class_exp <= cfg_data[CLASS_W-1:0];
        REG_SLAB_LIMIT: slab_limit    <= cfg_data[6:0];
        REG_REGION:     region_bytes  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_idx     <= '0;
      slabs_made  <= '0;
      bump_offset <= '0;
      pend        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= issue;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + IW'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if ((state == S_DECIDE) && !best.found && !pool_full && !no_space) begin
        slabs_made  <= slabs_made + NW'(1);
        bump_offset <= bump_offset + size;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op         <= opcode;
      req        <= request_bytes;
      rel_slab   <= release_slab;
      res_status <= ST_OK;
      res_slab   <= '0;
      res_addr   <= '0;
    end
    if (state == S_CLASS) begin
      cls      <= (cls_raw < {1'b0, min_class_exp}) ? {1'b0, min_class_exp} : cls_raw;
      scan_idx <= '0;
    end
    if (issue) begin
      scan_idx <= scan_idx + NW'(1);
      pend_idx <= scan_idx[IW-1:0];
    end
    if ((state == S_DECIDE) && (op == OP_ACQUIRE)) begin
      if (best.found) begin
        if (best.err) begin
          res_status <= ST_OVER;
        end else begin
          res_status <= ST_OK;
          res_slab   <= 6'(best_idx);
          res_addr   <= best.base;
        end
      end else if (pool_full) begin
        res_status <= ST_FULL;
      end else if (no_space) begin
        res_status <= ST_SPACE;
      end else begin
        res_status <= ST_OK;
        res_slab   <= 6'(slabs_made);
        res_addr   <= bump_offset[ADDR_W-1:0];
      end
    end
    if (out_load) begin
      status       <= res_status;
      granted_slab <= res_slab;
      slab_address <= res_addr;
    end
  end

endmodule

@@ sv/sar_ram.sv @@
module sar_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/sar_scan.sv @@
module sar_scan #(
  parameter int IW = 6
) (
  input  logic                           clk,
  input  logic                           start,
  input  logic                           ent_valid,
  input  sar_pkg::slab_ent_t             ent,
  input  logic [sar_pkg::CNT_W-1:0]      ent_rel,
  input  logic [IW-1:0]                  ent_idx,
  input  logic [sar_pkg::CLASS_W:0]      cls,
  output sar_pkg::best_t                 best,
  output logic [IW-1:0]                  best_idx
);
  import sar_pkg::*;

  logic take;

  // An entry competes when it is of the wanted class or above and not busy;
  // the lowest class wins, and the earliest slab within a class.
  always_comb begin
    take = ent_valid && ({1'b0, ent.cls} >= cls) && (ent.acq <= ent_rel) &&
           (!best.found || (ent.cls < best.cls));
  end

  always_ff @(posedge clk) begin
    if (start) begin
      best.found <= 1'b0;
    end else if (take) begin
      best.found <= 1'b1;
      best.err   <= (ent.acq != ent_rel);
      best.cls   <= ent.cls;
      best.base  <= ent.base;
      best.acq   <= ent.acq;
      best_idx   <= ent_idx;
    end
  end

endmodule
